// ===== src/mcpc_pkg.sv =====
package mcpc_pkg;

    // Default sizes of the coefficient store
    localparam int ROD_COUNT_DEF  = 3;
    localparam int COEF_COUNT_DEF = 7;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int ROD_W   = 2;
    localparam int CI_W    = 3;
    localparam int WORD_W  = 32;
    localparam int LIM_W   = 30;
    localparam int ITER_W  = 8;
    localparam int K_W     = 3;
    localparam int ACC_W   = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    // Divider operand widths: (error << 10) and the derivative accumulator
    localparam int DIV_NUM_W = 43;
    localparam int DIV_DEN_W = ACC_W;

    // Horner accumulator saturation bound
    localparam logic signed [ACC_W-1:0] ACC_LIM = 48'sh3FFF_FFFF_FFFF;

    // Register reset values
    localparam logic [LIM_W-1:0]  CURRENT_LIMIT_RST = 30'd107266808;
    localparam logic [LIM_W-1:0]  TOLERANCE_RST     = 30'd107374;
    localparam logic [LIM_W-1:0]  THRESHOLD_RST     = 30'd107374;
    localparam logic [ITER_W-1:0] MAX_ITER_RST      = 8'd100;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT_LIMIT = 2'd0,
        CFG_TOLERANCE     = 2'd1,
        CFG_THRESHOLD     = 2'd2,
        CFG_MAX_ITER      = 2'd3
    } cfg_idx_t;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD = 2'd0,
        REQ_FWD  = 2'd1,
        REQ_INV  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_STORE,
        OP_READ,
        OP_INIT,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_ACC,
        OP_FWD_OUT,
        OP_INV_SETUP,
        OP_DER_END,
        OP_DIV_START,
        OP_MOM_UPD,
        OP_NAMP,
        OP_NAMP_ZERO,
        OP_INV_OUT,
        OP_FINISH
    } op_t;

    // Controller to datapath
    typedef struct packed {
        op_t            op;
        logic           rd;
        logic [K_W-1:0] k;
        logic           deriv;
        logic           use_mom;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_t req;
        logic x_zero;
        logic small_cur;
        logic acc_zero;
        logic div_done;
        logic mom_zero;
        logic stop;
    } dp_stat_t;

endpackage

// ===== src/mcpc_if.sv =====
interface mcpc_in_if;
    logic                             valid;
    logic                             ready;
    logic [mcpc_pkg::REQ_W-1:0]       req_type;
    logic [mcpc_pkg::ROD_W-1:0]       rod;
    logic                             bank;
    logic [mcpc_pkg::CI_W-1:0]        coef_index;
    logic signed [mcpc_pkg::WORD_W-1:0] coef_value;
    logic signed [mcpc_pkg::WORD_W-1:0] operand;

    modport source (output valid, req_type, rod, bank, coef_index, coef_value, operand,
                    input ready);
    modport sink   (input valid, req_type, rod, bank, coef_index, coef_value, operand,
                    output ready);
endinterface

interface mcpc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [mcpc_pkg::WORD_W-1:0] result;
    logic                               was_clamped;
    logic                               converged;
    logic [mcpc_pkg::ITER_W-1:0]        iteration_count;
    logic                               div_fault;

    modport source (output valid, result, was_clamped, converged, iteration_count, div_fault,
                    input ready);
    modport sink   (input valid, result, was_clamped, converged, iteration_count, div_fault,
                    output ready);
endinterface

// ===== src/moment_current_polynomial_converter_core.sv =====
// Torque rod moment/current converter. Load items write one Q7.24 coefficient of a
// rod's negative or positive bank; forward items map a Q15.16 moment to a clamped
// Q1.30 current by Horner evaluation; inverse items map a current back to a moment
// by Newton iteration. One item is worked on at a time. Each Horner step runs through
// S_M0 to S_M3 and S_ACC: three partial products through the shared 17x32 multiplier,
// a final add and the accumulate. An inverse item runs up to max_iterations Newton
// steps (100 after reset), each a derivative pass, the bit-serial divider plus its
// hand-off and a forward pass. A finished result sits in an output register, and the
// next item is taken while it waits.
module moment_current_polynomial_converter_core #(
    parameter int ROD_COUNT  = mcpc_pkg::ROD_COUNT_DEF,
    parameter int COEF_COUNT = mcpc_pkg::COEF_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mcpc_in_if.sink                         in_ch,
    mcpc_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [mcpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcpc_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mcpc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mcpc_ctrl #(
        .COEF_COUNT (COEF_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mcpc_datapath #(
        .ROD_COUNT  (ROD_COUNT),
        .COEF_COUNT (COEF_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (in_ch.req_type),
        .rod             (in_ch.rod),
        .bank            (in_ch.bank),
        .coef_index      (in_ch.coef_index),
        .coef_value      (in_ch.coef_value),
        .operand         (in_ch.operand),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result          (out_ch.result),
        .was_clamped     (out_ch.was_clamped),
        .converged       (out_ch.converged),
        .iteration_count (out_ch.iteration_count),
        .div_fault       (out_ch.div_fault)
    );

endmodule

// ===== src/mcpc_ram.sv =====
module mcpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 42
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/mcpc_div.sv =====
// Signed restoring divider, one quotient bit per cycle, truncates toward zero
module mcpc_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] nq_reg;
    logic [DEN_W-1:0] dmag_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W-1:0] trial;
    logic             qbit;

    // Trial subtraction
    always_comb
    begin
        trial = {rem_reg[DEN_W-2:0], nq_reg[NUM_W-1]};
        qbit  = (trial >= dmag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dmag_reg <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            rem_reg  <= '0;
            neg_reg  <= num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? (trial - dmag_reg) : trial;
            nq_reg  <= {nq_reg[NUM_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(nq_reg) : $signed(nq_reg);

endmodule

// ===== src/mcpc_datapath.sv =====
module mcpc_datapath #(
    parameter int ROD_COUNT  = mcpc_pkg::ROD_COUNT_DEF,
    parameter int COEF_COUNT = mcpc_pkg::COEF_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcpc_pkg::dp_cmd_t                   cmd,
    output mcpc_pkg::dp_stat_t                  stat,
    input  logic [mcpc_pkg::REQ_W-1:0]          req_type,
    input  logic [mcpc_pkg::ROD_W-1:0]          rod,
    input  logic                                bank,
    input  logic [mcpc_pkg::CI_W-1:0]           coef_index,
    input  logic signed [mcpc_pkg::WORD_W-1:0]  coef_value,
    input  logic signed [mcpc_pkg::WORD_W-1:0]  operand,
    input  logic                                cfg_we,
    input  logic [mcpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic signed [mcpc_pkg::WORD_W-1:0]  result,
    output logic                                was_clamped,
    output logic                                converged,
    output logic [mcpc_pkg::ITER_W-1:0]         iteration_count,
    output logic                                div_fault
);

    import mcpc_pkg::*;

    localparam int DEPTH = ROD_COUNT * 2 * COEF_COUNT;
    localparam int AW    = $clog2(DEPTH);

    // Configuration registers
    logic [LIM_W-1:0]  lim_reg;
    logic [LIM_W-1:0]  tol_reg;
    logic [LIM_W-1:0]  thr_reg;
    logic [ITER_W-1:0] maxit_reg;

    // Captured item
    req_t                     req_reg;
    logic [ROD_W-1:0]         rod_reg;
    logic                     bank_reg;
    logic [CI_W-1:0]          ci_reg;
    logic [WORD_W-1:0]        coefv_reg;
    logic signed [WORD_W-1:0] opnd_reg;

    // Working registers
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [48:0]       prod_reg;
    logic signed [79:0]       sum_reg;
    logic signed [WORD_W-1:0] mom_reg;
    logic signed [WORD_W-1:0] amp_reg;
    logic signed [WORD_W-1:0] namp_reg;
    logic                     dbank_reg;

    // Working result
    logic signed [WORD_W-1:0] res_reg;
    logic                     clamped_reg;
    logic                     conv_reg;
    logic [ITER_W-1:0]        iters_reg;
    logic                     fault_reg;

    // Output payload
    logic signed [WORD_W-1:0] out_res_reg;
    logic                     out_clamped_reg;
    logic                     out_conv_reg;
    logic [ITER_W-1:0]        out_iters_reg;
    logic                     out_fault_reg;

    logic                     rod_ok;
    logic                     load_ok;
    logic signed [WORD_W-1:0] x_sel;
    logic                     rd_bank;
    logic [AW-1:0]            raddr;
    logic [AW-1:0]            waddr;
    logic [WORD_W-1:0]        rdata;
    logic signed [WORD_W-1:0] coef_s;
    logic [K_W-1:0]           scale;
    logic signed [35:0]       term;
    logic signed [16:0]       chunk;
    logic signed [48:0]       prod_next;
    logic signed [79:0]       prod_ext;
    logic signed [65:0]       acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;
    logic signed [55:0]       cur;
    logic signed [55:0]       lim_ext;
    logic signed [WORD_W-1:0] cur_clamped;
    logic                     fwd_clip;
    logic signed [32:0]       op33;
    logic signed [32:0]       lim33;
    logic [WORD_W-1:0]        abs_op;
    logic signed [WORD_W-1:0] amp_clamped;
    logic                     amp_clip;
    logic signed [32:0]       err;
    logic [32:0]              err_abs;
    logic                     in_tol;
    logic signed [DIV_NUM_W-1:0] div_num;
    logic signed [DIV_NUM_W-1:0] div_quo;
    logic                     div_done;
    logic signed [43:0]       mom_sum;
    logic signed [WORD_W-1:0] mom_sat;

    // Coefficient store
    mcpc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.op == OP_STORE && load_ok),
        .waddr (waddr),
        .wdata (coefv_reg),
        .re    (cmd.rd),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Newton correction divider
    mcpc_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV_START),
        .num   (div_num),
        .den   (acc_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Store addressing
    always_comb
    begin
        rod_ok  = (32'(rod_reg) < ROD_COUNT);
        load_ok = rod_ok && (32'(ci_reg) < COEF_COUNT);
        x_sel   = cmd.use_mom ? mom_reg : opnd_reg;
        rd_bank = cmd.deriv ? dbank_reg : ~x_sel[WORD_W-1];
        raddr   = rod_ok ? AW'((32'(rod_reg) * 2 + 32'(rd_bank)) * COEF_COUNT + 32'(cmd.k))
                         : '0;
        waddr   = load_ok ? AW'((32'(rod_reg) * 2 + 32'(bank_reg)) * COEF_COUNT
                                + 32'(ci_reg)) : '0;
    end

    // Horner term and partial products
    always_comb
    begin
        coef_s = rod_ok ? $signed(rdata) : '0;
        scale  = cmd.deriv ? cmd.k : K_W'(1);
        term   = coef_s * $signed({1'b0, scale});
        case (cmd.op)
            OP_MUL0: chunk = $signed({1'b0, acc_reg[15:0]});
            OP_MUL1: chunk = $signed({1'b0, acc_reg[31:16]});
            default: chunk = $signed({acc_reg[47], acc_reg[47:32]});
        endcase
        prod_next = chunk * x_sel;
        prod_ext  = 80'(prod_reg);
        acc_sum   = 66'($signed(sum_reg[79:16])) + 66'(term);
        if (acc_sum > 66'(ACC_LIM))
        begin
            acc_sat = ACC_LIM;
        end
        else if (acc_sum < -66'(ACC_LIM))
        begin
            acc_sat = -ACC_LIM;
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // Current scaling and clamp
    always_comb
    begin
        cur     = $signed({{2{acc_reg[ACC_W-1]}}, acc_reg, 6'b0});
        lim_ext = $signed({26'b0, lim_reg});
        fwd_clip = 1'b1;
        if (cur > lim_ext)
        begin
            cur_clamped = WORD_W'(lim_ext);
        end
        else if (cur < -lim_ext)
        begin
            cur_clamped = WORD_W'(-lim_ext);
        end
        else
        begin
            cur_clamped = cur[WORD_W-1:0];
            fwd_clip    = 1'b0;
        end
    end

    // Inverse input conditioning, error and moment update
    always_comb
    begin
        op33   = 33'(opnd_reg);
        lim33  = $signed({3'b0, lim_reg});
        abs_op = opnd_reg[WORD_W-1] ? WORD_W'(-op33) : WORD_W'(op33);
        amp_clip = 1'b1;
        if (op33 > lim33)
        begin
            amp_clamped = WORD_W'(lim33);
        end
        else if (op33 < -lim33)
        begin
            amp_clamped = WORD_W'(-lim33);
        end
        else
        begin
            amp_clamped = opnd_reg;
            amp_clip    = 1'b0;
        end
        err     = 33'(amp_reg) - 33'(namp_reg);
        err_abs = err[32] ? 33'(-err) : 33'(err);
        in_tol  = (err_abs <= {3'b0, tol_reg});
        div_num = {err, 10'b0};
        mom_sum = 44'(mom_reg) + 44'(div_quo);
        if (mom_sum > 44'sh0_7FFF_FFFF)
        begin
            mom_sat = 32'sh7FFF_FFFF;
        end
        else if (mom_sum < -44'sh0_8000_0000)
        begin
            mom_sat = 32'sh8000_0000;
        end
        else
        begin
            mom_sat = mom_sum[WORD_W-1:0];
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.req       = req_reg;
        stat.x_zero    = (opnd_reg == '0);
        stat.small_cur = (abs_op < {2'b0, thr_reg});
        stat.acc_zero  = (acc_reg == '0);
        stat.div_done  = div_done;
        stat.mom_zero  = (mom_reg == '0);
        stat.stop      = (iters_reg >= maxit_reg) || in_tol;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg   <= CURRENT_LIMIT_RST;
            tol_reg   <= TOLERANCE_RST;
            thr_reg   <= THRESHOLD_RST;
            maxit_reg <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CURRENT_LIMIT: lim_reg   <= cfg_data;
                CFG_TOLERANCE:     tol_reg   <= cfg_data;
                CFG_THRESHOLD:     thr_reg   <= cfg_data;
                CFG_MAX_ITER:      maxit_reg <= cfg_data[ITER_W-1:0];
                default:           lim_reg   <= lim_reg;
            endcase
        end
    end

    // Datapath operations
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                req_reg     <= req_t'(req_type);
                rod_reg     <= rod;
                bank_reg    <= bank;
                ci_reg      <= coef_index;
                coefv_reg   <= coef_value;
                opnd_reg    <= operand;
                res_reg     <= '0;
                clamped_reg <= 1'b0;
                conv_reg    <= 1'b1;
                iters_reg   <= '0;
                fault_reg   <= 1'b0;
            end
            OP_INIT:
            begin
                acc_reg <= ACC_W'(term);
            end
            OP_MUL0:
            begin
                prod_reg <= prod_next;
                sum_reg  <= '0;
            end
            OP_MUL1:
            begin
                prod_reg <= prod_next;
                sum_reg  <= sum_reg + prod_ext;
            end
            OP_MUL2:
            begin
                prod_reg <= prod_next;
                sum_reg  <= sum_reg + (prod_ext <<< 16);
            end
            OP_MUL3:
            begin
                sum_reg <= sum_reg + (prod_ext <<< 32);
            end
            OP_ACC:
            begin
                acc_reg <= acc_sat;
            end
            OP_FWD_OUT:
            begin
                res_reg     <= cur_clamped;
                clamped_reg <= fwd_clip;
            end
            OP_INV_SETUP:
            begin
                amp_reg     <= amp_clamped;
                clamped_reg <= amp_clip;
                dbank_reg   <= (amp_clamped > 0);
                mom_reg     <= '0;
                namp_reg    <= '0;
            end
            OP_DER_END:
            begin
                iters_reg <= iters_reg + 1'b1;
                if (acc_reg == '0)
                begin
                    fault_reg <= 1'b1;
                    conv_reg  <= 1'b0;
                    res_reg   <= (err > 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                end
            end
            OP_MOM_UPD:
            begin
                mom_reg <= mom_sat;
            end
            OP_NAMP:
            begin
                namp_reg <= cur_clamped;
            end
            OP_NAMP_ZERO:
            begin
                namp_reg <= '0;
            end
            OP_INV_OUT:
            begin
                res_reg  <= mom_reg;
                conv_reg <= in_tol;
            end
            OP_FINISH:
            begin
                out_res_reg     <= res_reg;
                out_clamped_reg <= clamped_reg;
                out_conv_reg    <= conv_reg;
                out_iters_reg   <= iters_reg;
                out_fault_reg   <= fault_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign result          = out_res_reg;
    assign was_clamped     = out_clamped_reg;
    assign converged       = out_conv_reg;
    assign iteration_count = out_iters_reg;
    assign div_fault       = out_fault_reg;

endmodule

// ===== src/mcpc_ctrl.sv =====
module mcpc_ctrl #(
    parameter int COEF_COUNT = mcpc_pkg::COEF_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output mcpc_pkg::dp_cmd_t  cmd,
    input  mcpc_pkg::dp_stat_t stat
);

    import mcpc_pkg::*;

    localparam logic [K_W-1:0] K_TOP = K_W'(COEF_COUNT - 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_STORE,
        S_INV_SETUP,
        S_EV_RD,
        S_EV_INIT,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_ACC,
        S_EV_END,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MOM_CHK,
        S_CHECK,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        M_FWD,
        M_DER,
        M_NMP
    } mode_t;

    state_t         state_reg;
    mode_t          mode_reg;
    logic [K_W-1:0] k_reg;
    logic           out_valid_reg;
    logic           deriv;
    logic [K_W-1:0] k_low;

    always_comb
    begin
        deriv = (mode_reg == M_DER);
        k_low = deriv ? K_W'(1) : '0;
    end

    // Command decode
    always_comb
    begin
        cmd.op      = OP_NOP;
        cmd.rd      = 1'b0;
        cmd.k       = k_reg;
        cmd.deriv   = deriv;
        cmd.use_mom = (mode_reg != M_FWD);
        case (state_reg)
            S_IDLE:      cmd.op = in_valid ? OP_CAPTURE : OP_NOP;
            S_STORE:     cmd.op = OP_STORE;
            S_INV_SETUP: cmd.op = OP_INV_SETUP;
            S_EV_RD:
            begin
                cmd.op = OP_READ;
                cmd.rd = 1'b1;
                cmd.k  = K_TOP;
            end
            S_EV_INIT:
            begin
                cmd.op = OP_INIT;
                cmd.k  = K_TOP;
            end
            S_M0:        cmd.op = OP_MUL0;
            S_M1:        cmd.op = OP_MUL1;
            S_M2:        cmd.op = OP_MUL2;
            S_M3:
            begin
                cmd.op = OP_MUL3;
                cmd.rd = 1'b1;
            end
            S_ACC:       cmd.op = OP_ACC;
            S_EV_END:
            begin
                case (mode_reg)
                    M_FWD:   cmd.op = OP_FWD_OUT;
                    M_DER:   cmd.op = OP_DER_END;
                    default: cmd.op = OP_NAMP;
                endcase
            end
            S_DIV_GO:    cmd.op = OP_DIV_START;
            S_DIV_WAIT:  cmd.op = stat.div_done ? OP_MOM_UPD : OP_NOP;
            S_MOM_CHK:   cmd.op = stat.mom_zero ? OP_NAMP_ZERO : OP_NOP;
            S_CHECK:     cmd.op = OP_INV_OUT;
            S_DONE:      cmd.op = (!out_valid_reg || out_ready) ? OP_FINISH : OP_NOP;
            default:     cmd.op = OP_NOP;
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_FWD;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // S_DONE handles its own output transfer
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    case (stat.req)
                        REQ_LOAD: state_reg <= S_STORE;
                        REQ_FWD:
                        begin
                            mode_reg  <= M_FWD;
                            state_reg <= stat.x_zero ? S_DONE : S_EV_RD;
                        end
                        REQ_INV:  state_reg <= stat.small_cur ? S_DONE : S_INV_SETUP;
                        default:  state_reg <= S_DONE;
                    endcase
                end
                S_STORE:
                begin
                    state_reg <= S_DONE;
                end
                S_INV_SETUP:
                begin
                    mode_reg  <= M_DER;
                    state_reg <= S_EV_RD;
                end
                S_EV_RD:
                begin
                    k_reg     <= K_TOP - 1'b1;
                    state_reg <= S_EV_INIT;
                end
                S_EV_INIT:
                begin
                    state_reg <= (k_reg < k_low) ? S_EV_END : S_M0;
                end
                S_M0: state_reg <= S_M1;
                S_M1: state_reg <= S_M2;
                S_M2: state_reg <= S_M3;
                S_M3: state_reg <= S_ACC;
                S_ACC:
                begin
                    if (k_reg == k_low)
                    begin
                        state_reg <= S_EV_END;
                    end
                    else
                    begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= S_M0;
                    end
                end
                S_EV_END:
                begin
                    case (mode_reg)
                        M_FWD:   state_reg <= S_DONE;
                        M_DER:   state_reg <= stat.acc_zero ? S_DONE : S_DIV_GO;
                        default: state_reg <= S_CHECK;
                    endcase
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_MOM_CHK;
                    end
                end
                S_MOM_CHK:
                begin
                    if (stat.mom_zero)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        mode_reg  <= M_NMP;
                        state_reg <= S_EV_RD;
                    end
                end
                S_CHECK:
                begin
                    if (stat.stop)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        mode_reg  <= M_DER;
                        state_reg <= S_EV_RD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/mcpc_checker.sv =====
module mcpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result,
    input logic        converged,
    input logic [7:0]  iteration_count,
    input logic        div_fault
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result changed while stalled");

    // One item at a time: no transfer back to back
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // A fault ends an inverse item that ran and did not converge
    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_fault |-> !converged && iteration_count != 8'd0)
        else $error("fault without iteration");

    // Only an inverse item that iterated can miss convergence
    a_nonconv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !converged |-> iteration_count != 8'd0)
        else $error("non-converged result with no iteration");

endmodule

bind moment_current_polynomial_converter_core mcpc_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .result          (out_ch.result),
    .converged       (out_ch.converged),
    .iteration_count (out_ch.iteration_count),
    .div_fault       (out_ch.div_fault)
);

// ===== tb/sv/testbench.sv =====
module testbench;
    import mcpc_pkg::*;

    localparam int RODS       = 3;
    localparam int COEFS      = 7;
    localparam int CYCLE_CAP  = 10000000;
    localparam longint SAT_ACC = 64'sh3FFF_FFFF_FFFF;
    localparam longint W_MAX  = 64'sd2147483647;
    localparam longint W_MIN  = -64'sd2147483648;

    typedef struct {
        req_t        req;
        logic [1:0]  rod;
        logic        bank;
        logic [2:0]  ci;
        logic [31:0] cval;
        logic [31:0] opnd;
    } conv_req_t;

    typedef struct {
        logic [31:0] value;
        logic        clamped;
        logic        conv;
        logic [7:0]  iters;
        logic        fault;
    } conv_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mcpc_in_if  in_ch ();
    mcpc_out_if out_ch ();

    moment_current_polynomial_converter_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // mirror of the block's coefficient store and registers
    logic [31:0] coef_mem [RODS*2*COEFS];
    longint      lim_reg;
    longint      tol_reg;
    longint      thr_reg;
    int unsigned iter_cap;

    conv_req_t pending_q[$];
    conv_res_t expected_q[$];
    int        errors;
    int        gap_pct;
    int        stall_pct;
    logic      in_taken;
    int        cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip(longint x, longint lo, longint hi);
        return x > hi ? hi : (x < lo ? lo : x);
    endfunction

    function automatic longint coef_at(int rod, int bank, int k);
        if (rod >= RODS)
            return 0;
        return longint'($signed(coef_mem[(rod*2 + bank)*COEFS + k]));
    endfunction

    // floor(a * m / 2^16)
    function automatic longint scale_mul(longint a, longint m);
        longint hi;
        longint lo;
        hi = a >>> 16;
        lo = a - hi * 65536;
        return hi * m + ((lo * m) >>> 16);
    endfunction

    // moment Q15.16 to current Q1.30
    function automatic longint moment_to_current(longint m, int rod, output logic clamped);
        longint acc;
        longint cur;
        int bank;
        clamped = 1'b0;
        if (m == 0)
            return 0;
        bank = m < 0 ? 0 : 1;
        acc = coef_at(rod, bank, COEFS-1);
        for (int k = COEFS-2; k >= 0; k--)
            acc = clip(coef_at(rod, bank, k) + scale_mul(acc, m), -SAT_ACC, SAT_ACC);
        cur = acc * 64;
        if (cur > lim_reg)
        begin
            cur = lim_reg;
            clamped = 1'b1;
        end
        if (cur < -lim_reg)
        begin
            cur = -lim_reg;
            clamped = 1'b1;
        end
        return cur;
    endfunction

    function automatic longint slope_at(longint m, int rod, int bank);
        longint acc;
        acc = longint'(COEFS-1) * coef_at(rod, bank, COEFS-1);
        for (int k = COEFS-2; k >= 1; k--)
            acc = clip(longint'(k) * coef_at(rod, bank, k) + scale_mul(acc, m),
                       -SAT_ACC, SAT_ACC);
        return acc;
    endfunction

    function automatic longint mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    // expected outcome of one item; load items update the mirror store
    function automatic conv_res_t convert(conv_req_t it);
        conv_res_t r;
        longint amp;
        longint mom;
        longint namp;
        longint err;
        longint d;
        int dbank;
        logic junk;
        r = '{value: '0, clamped: 1'b0, conv: 1'b1, iters: '0, fault: 1'b0};
        case (it.req)
            REQ_LOAD:
                if (it.rod < RODS && it.ci < COEFS)
                    coef_mem[(it.rod*2 + it.bank)*COEFS + it.ci] = it.cval;
            REQ_FWD:
                r.value = 32'(moment_to_current(longint'($signed(it.opnd)), it.rod, r.clamped));
            REQ_INV:
            begin
                amp = longint'($signed(it.opnd));
                if (mag(amp) >= thr_reg)
                begin
                    mom = 0;
                    namp = 0;
                    if (amp > lim_reg)
                    begin
                        amp = lim_reg;
                        r.clamped = 1'b1;
                    end
                    if (amp < -lim_reg)
                    begin
                        amp = -lim_reg;
                        r.clamped = 1'b1;
                    end
                    dbank = amp > 0 ? 1 : 0;
                    forever
                    begin
                        err = amp - namp;
                        d = slope_at(mom, it.rod, dbank);
                        r.iters++;
                        if (d == 0)
                        begin
                            r.fault = 1'b1;
                            mom = err > 0 ? W_MAX : W_MIN;
                            break;
                        end
                        mom = clip(mom + (err * 1024) / d, W_MIN, W_MAX);
                        namp = moment_to_current(mom, it.rod, junk);
                        if (r.iters >= iter_cap || mag(namp - amp) <= tol_reg)
                            break;
                    end
                    r.conv = !r.fault && mag(namp - amp) <= tol_reg;
                    r.value = 32'(mom);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: present queued items, random gaps between transfers
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_taken))
        begin
            if (pending_q.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                in_ch.valid      <= 1'b1;
                in_ch.req_type   <= pending_q[0].req;
                in_ch.rod        <= pending_q[0].rod;
                in_ch.bank       <= pending_q[0].bank;
                in_ch.coef_index <= pending_q[0].ci;
                in_ch.coef_value <= pending_q[0].cval;
                in_ch.operand    <= pending_q[0].opnd;
                void'(pending_q.pop_front());
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // input transfers feed the predictor
    always @(posedge clk)
    begin
        conv_req_t it;
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            it.req  = req_t'(in_ch.req_type);
            it.rod  = in_ch.rod;
            it.bank = in_ch.bank;
            it.ci   = in_ch.coef_index;
            it.cval = in_ch.coef_value;
            it.opnd = in_ch.operand;
            expected_q.push_back(convert(it));
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        conv_res_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_ch.result);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.result !== e.value || out_ch.was_clamped !== e.clamped ||
                    out_ch.converged !== e.conv || out_ch.iteration_count !== e.iters ||
                    out_ch.div_fault !== e.fault)
                begin
                    $display("%0t: expected %h clamp %b conv %b iter %0d fault %b", $time,
                             e.value, e.clamped, e.conv, e.iters, e.fault);
                    $display("%0t: actual   %h clamp %b conv %b iter %0d fault %b", $time,
                             out_ch.result, out_ch.was_clamped, out_ch.converged,
                             out_ch.iteration_count, out_ch.div_fault);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_item(req_t req, int rod, int bank, int ci, logic [31:0] cval,
                            logic [31:0] opnd);
        conv_req_t it;
        it.req  = req;
        it.rod  = 2'(rod);
        it.bank = 1'(bank);
        it.ci   = 3'(ci);
        it.cval = cval;
        it.opnd = opnd;
        pending_q.push_back(it);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int unsigned value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        case (idx)
            CFG_CURRENT_LIMIT: lim_reg  = longint'(value & 32'h3FFF_FFFF);
            CFG_TOLERANCE:     tol_reg  = longint'(value & 32'h3FFF_FFFF);
            CFG_THRESHOLD:     thr_reg  = longint'(value & 32'h3FFF_FFFF);
            default:           iter_cap = value & 8'hFF;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_regs(int unsigned lim, int unsigned tol, int unsigned thr,
                            int unsigned its);
        write_reg(CFG_CURRENT_LIMIT, lim);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_MAX_ITER, its);
    endtask

    // a well-behaved coefficient: strong linear term, small others
    function automatic logic [31:0] sane_coef(int ci);
        if (ci == 1)
            return 32'($urandom_range(1200000, 400000));
        return 32'($signed($urandom_range(40000)) - 20000);
    endfunction

    task automatic random_items(int count);
        int sel;
        int ci;
        logic [31:0] op;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            op = $urandom_range(3) == 0 ? $urandom() :
                 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
            if (sel < 15)
            begin
                ci = $urandom_range(6);
                if ($urandom_range(9) == 0)
                    add_item(REQ_LOAD, $urandom_range(3), $urandom_range(1), 7,
                             $urandom(), $urandom());
                else
                    add_item(REQ_LOAD, $urandom_range(2), $urandom_range(1), ci,
                             sane_coef(ci), $urandom());
            end
            else if (sel < 55)
                add_item(REQ_FWD, $urandom_range(3), $urandom_range(1), $urandom_range(7),
                         $urandom(), op);
            else if (sel < 95)
                add_item(REQ_INV, $urandom_range(3), $urandom_range(1), $urandom_range(7),
                         $urandom(), op);
            else
                add_item(REQ_NONE, $urandom_range(3), $urandom_range(1), $urandom_range(7),
                         $urandom(), $urandom());
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        in_taken = 1'b0;
        gap_pct = 32;
        stall_pct = 55;
        cfg_we = 1'b0;
        cfg_index = CFG_CURRENT_LIMIT;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_NONE;
        in_ch.rod = '0;
        in_ch.bank = 1'b0;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.operand = '0;
        out_ch.ready = 1'b0;
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        lim_reg  = 107266808;
        tol_reg  = 107374;
        thr_reg  = 107374;
        iter_cap = 100;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_regs(107266808, 107374, 107374, 30);

        // fill the whole store before any evaluation reads it
        for (int r = 0; r < RODS; r++)
            for (int b = 0; b < 2; b++)
                for (int k = 0; k < COEFS; k++)
                    add_item(REQ_LOAD, r, b, k, sane_coef(k), '0);

        // directed corners
        add_item(REQ_LOAD, 3, 1, 2, 32'h7FFF_FFFF, '0);            // bad rod, ignored
        add_item(REQ_LOAD, 0, 0, 7, 32'h8000_0000, 32'hFFFF_FFFF); // bad index, ignored
        add_item(REQ_NONE, 2, 1, 5, 32'hFFFF_FFFF, 32'h1234_5678);
        add_item(REQ_FWD, 0, 0, 0, '0, '0);                        // zero moment
        add_item(REQ_FWD, 1, 0, 0, '0, 32'h7FFF_FFFF);             // clamps high
        add_item(REQ_FWD, 1, 0, 0, '0, 32'h8000_0000);             // clamps low
        add_item(REQ_FWD, 2, 0, 0, '0, 32'h0001_0000);
        add_item(REQ_FWD, 3, 0, 0, '0, 32'h0001_0000);             // bad rod reads zeros
        add_item(REQ_INV, 0, 0, 0, '0, 32'd100);                   // below threshold
        add_item(REQ_INV, 0, 0, 0, '0, 32'h0200_0000);
        add_item(REQ_INV, 1, 0, 0, '0, 32'hFE00_0000);
        add_item(REQ_INV, 2, 0, 0, '0, 32'h7FFF_FFFF);             // input clamped
        add_item(REQ_INV, 2, 0, 0, '0, 32'h8000_0000);
        add_item(REQ_INV, 3, 0, 0, '0, 32'h0100_0000);             // zero slope, positive
        add_item(REQ_INV, 3, 0, 0, '0, 32'hFF00_0000);             // zero slope, negative
        add_item(REQ_LOAD, 2, 1, 6, 32'h7FFF_FFFF, '0);            // huge top term
        add_item(REQ_FWD, 2, 0, 0, '0, 32'h7FFF_FFFF);             // accumulator saturates
        add_item(REQ_LOAD, 2, 1, 6, 32'd1000, '0);
        drain();

        // random phases under different register settings and idling
        random_items(40);
        drain();
        gap_pct = 55;
        stall_pct = 32;
        set_regs(30'h3FFF_FFFF, 0, 0, 1);
        random_items(40);
        drain();                                                   // sender holds off
        random_items(40);
        drain();
        gap_pct = 0;
        stall_pct = 0;
        set_regs(0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 255);
        random_items(40);
        drain();
        set_regs(50000000, 2000, 50000, 12);
        random_items(40);
        drain();
        set_regs(107266808, 107374, 107374, 20);
        random_items(40);
        drain();
        repeat (200) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/mcpc_pkg.sv
src/mcpc_if.sv
src/mcpc_ram.sv
src/mcpc_div.sv
src/mcpc_datapath.sv
src/mcpc_ctrl.sv
src/moment_current_polynomial_converter_core.sv
src/mcpc_checker.sv
tb/sv/testbench.sv
